[rtl/fqs_pkg.sv]
// fqs_pkg: shared constants, types and ring-index helpers for the fifo queue with search
// depends on nothing; used by fqs_ram users and by fifo_queue_with_search_unit
`timescale 1ns / 1ps

package fqs_pkg;

    // queue geometry
    localparam int DEPTH  = 16;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;
    localparam int POS_W  = 4;

    typedef logic [AW-1:0]     t_addr;
    typedef logic [CW-1:0]     t_cnt;
    typedef logic [WORD_W-1:0] t_word;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [POS_W-1:0]  t_pos;

    // request codes
    localparam t_mode MODE_ENQ    = MODE_W'(0);
    localparam t_mode MODE_DEQ    = MODE_W'(1);
    localparam t_mode MODE_PEEKF  = MODE_W'(2);
    localparam t_mode MODE_PEEKR  = MODE_W'(3);
    localparam t_mode MODE_SEARCH = MODE_W'(4);

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } t_state;

    // ring slot after a
    function automatic t_addr ring_next(input t_addr a);
        ring_next = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    // ring slot before a
    function automatic t_addr ring_prev(input t_addr a);
        ring_prev = (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
    endfunction

endpackage

[rtl/fqs_ram.sv]
// fqs_ram: generic single-write, single-read memory with registered read data
// depends on nothing
`timescale 1ns / 1ps

module fqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/fifo_queue_with_search_unit.sv]
// fifo_queue_with_search_unit: ring-buffer fifo of 32-bit words with a sequential key search
// depends on fqs_pkg and fqs_ram
//
//   channel   handshake          payload
//   request   start / busy       i_mode, i_value, i_key
//   result    o_valid (strobe)   o_status, o_data, o_position
//
// enqueue, unused codes and any request on an empty queue: result in the cycle after accept
// dequeue and peeks: one ram read; ram read register, then S_READ registers the result
// search: one entry per cycle through the single ram read port, comparing at most
//   occupancy entries (DEPTH worst case) in S_SCAN before the result is registered
// busy is high in S_READ and S_SCAN, low with the result strobe; results cannot be stalled
// synchronous active-low reset clears pointers and count; entries are not cleared
`timescale 1ns / 1ps

module fifo_queue_with_search_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  fqs_pkg::t_mode                     i_mode,
    input  logic signed [fqs_pkg::WORD_W-1:0]  i_value,
    input  logic signed [fqs_pkg::WORD_W-1:0]  i_key,
    output logic                               o_valid,
    output logic [fqs_pkg::STAT_W-1:0]         o_status,
    output logic signed [fqs_pkg::WORD_W-1:0]  o_data,
    output logic [fqs_pkg::POS_W-1:0]          o_position
);

    import fqs_pkg::*;

    t_state  r_state, n_state;
    t_addr   r_head, n_head;
    t_addr   r_tail, n_tail;
    t_cnt    r_occ, n_occ;
    t_addr   r_ptr, n_ptr;
    t_cnt    r_cnt, n_cnt;
    t_word   r_key, n_key;
    logic    r_valid, n_valid;
    t_status r_status, n_status;
    t_word   r_data, n_data;
    t_pos    r_pos, n_pos;

    logic    wr_en;
    t_addr   rd_addr;
    t_word   rd_data;
    logic    accept;
    logic    full;
    logic    empty;

    assign accept = start && (r_state == S_IDLE);
    assign full   = (r_occ == CW'(DEPTH));
    assign empty  = (r_occ == '0);

    // entry storage
    fqs_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_tail),
        .i_wr_data(t_word'(i_value)),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_valid <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_cnt    <= n_cnt;
        r_key    <= n_key;
        r_status <= n_status;
        r_data   <= n_data;
        r_pos    <= n_pos;
    end

    // sequencer: next state, pointer updates, ram control and result
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_occ    = r_occ;
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_key    = r_key;
        n_valid  = 1'b0;
        n_status = r_status;
        n_data   = r_data;
        n_pos    = r_pos;
        wr_en    = 1'b0;
        rd_addr  = r_head;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_data   = '0;
                    n_pos    = '0;
                    case (i_mode)
                        MODE_ENQ: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en  = 1'b1;
                                n_tail = ring_next(r_tail);
                                n_occ  = r_occ + CW'(1);
                            end
                        end
                        MODE_DEQ, MODE_PEEKF, MODE_PEEKR: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_READ;
                                if (i_mode == MODE_PEEKR) begin
                                    rd_addr = ring_prev(r_tail);
                                end
                                if (i_mode == MODE_DEQ) begin
                                    n_head = ring_next(r_head);
                                    n_occ  = r_occ - CW'(1);
                                end
                            end
                        end
                        MODE_SEARCH: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                                n_ptr   = r_head;
                                n_cnt   = '0;
                                n_key   = t_word'(i_key);
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                // ram output holds the requested entry
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_data   = rd_data;
                n_pos    = '0;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                // compare the entry at r_ptr while fetching the next one
                rd_addr = ring_next(r_ptr);
                n_ptr   = ring_next(r_ptr);
                n_cnt   = r_cnt + CW'(1);
                if (rd_data == r_key) begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                    n_data   = rd_data;
                    n_pos    = t_pos'(r_cnt);
                    n_state  = S_IDLE;
                end else if ((r_cnt + CW'(1)) == r_occ) begin
                    n_valid  = 1'b1;
                    n_status = ST_NOTFOUND;
                    n_data   = '0;
                    n_pos    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_valid;
    assign o_status   = r_status;
    assign o_data     = r_data;
    assign o_position = r_pos;

`ifndef SYNTH
    // count never exceeds the ring size
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    // a result is never shown while a request is still in progress
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted enqueue with room grows the queue by one
    a_enq_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_ENQ && !full) |=> (r_occ == $past(r_occ) + CW'(1)))
        else $error("enqueue did not grow occupancy");

    // the search offset stays inside the held entries
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt < r_occ))
        else $error("search ran past occupancy");

    // every scan that ends is followed by a result strobe
    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && n_state == S_IDLE) |=> o_valid)
        else $error("search ended without a result");
`endif

endmodule
